// ===== hdl/afir_pkg.sv =====
package afir_pkg;

	// sizes of the stores and the datapath
	localparam int MAX_TAPS    = 1024;
	localparam int ADDR_BITS   = $clog2(MAX_TAPS);
	localparam int TAP_BITS    = ADDR_BITS + 1;
	localparam int SAMPLE_BITS = 16;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int ACC_BITS    = 42;

	localparam logic [TAP_BITS-1:0] TAPS_FULL = TAP_BITS'(MAX_TAPS);
	localparam logic [TAP_BITS-1:0] TAPS_ONE  = TAP_BITS'(1);

	// item commands
	typedef enum logic [1:0] {
		CMD_WR_COEF = 2'd0,
		CMD_PUSH    = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_HOLD
	} state_t;

endpackage

// ===== hdl/afir_ram.sv =====
module afir_ram #(
	parameter int WIDTH     = 16,
	parameter int DEPTH     = 1024,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [WIDTH-1:0]     rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/audio_convolution_fir.sv =====
// channel  | handshake               | payload
// ---------+-------------------------+------------------------------------------
// in       | in_valid / in_stall     | command, coeff_index, coeff_value, sample
// out      | out_valid / out_stall   | filtered_sample
// cfg      | cfg_valid / cfg_ready   | tap_count
//
// A coefficient write, a clear or an unused command leaves the block idle.
// A push walks m taps, m = min(taps in use, samples since clear):
// one shared multiply-accumulate reads one coefficient and one history
// entry per cycle from the two RAMs, then the read stage and the product
// stage drain before the sum is done.
// Reset clears control, the history pointer and the fill count; history
// reads beyond the fill count are skipped, so no clearing pass is needed.
// A new item is taken while a result waits in the output register; a push
// that finishes while that register is stalled holds its sum until free.
module audio_convolution_fir import afir_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [TAP_BITS-1:0]        tap_count,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [ADDR_BITS-1:0]       coeff_index,
	input  logic signed [SAMPLE_BITS-1:0] coeff_value,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [ACC_BITS-1:0] filtered_sample
);

	state_t state_q, state_d;

	logic [TAP_BITS-1:0]  tap_q;
	logic [ADDR_BITS-1:0] ptr_q;
	logic [TAP_BITS-1:0]  fill_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [ADDR_BITS-1:0] k_q;
	logic [TAP_BITS-1:0]  m_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic                 out_valid_q;
	logic signed [ACC_BITS-1:0] out_q;

	logic v_s1, last_s1, v_s2, last_s2;
	logic signed [PROD_BITS-1:0] prod_s2;

	logic accept, push, issue, last_issue, out_free, finish;
	logic [TAP_BITS-1:0] taps_used, fill_next, m_next;
	logic [SAMPLE_BITS-1:0] coef_rd, hist_rd;
	logic signed [ACC_BITS-1:0] acc_sum;

	assign cfg_ready = 1'b1;

	// handshake decode
	assign accept   = in_valid && !in_stall;
	assign push     = accept && (cmd_t'(command) == CMD_PUSH);
	assign out_free = !out_valid_q || !out_stall;
	assign last_issue = ({1'b0, k_q} == (m_q - TAPS_ONE));
	assign finish   = v_s2 && last_s2;

	// taps in use and length of this push's walk
	always_comb begin
		if (tap_q == '0) begin
			taps_used = TAPS_ONE;
		end else if (tap_q > TAPS_FULL) begin
			taps_used = TAPS_FULL;
		end else begin
			taps_used = tap_q;
		end
		fill_next = (fill_q == TAPS_FULL) ? TAPS_FULL : fill_q + TAPS_ONE;
		m_next    = (taps_used < fill_next) ? taps_used : fill_next;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (push) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (finish) begin
					state_d = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		issue    = (state_q == ST_ISSUE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= TAPS_ONE;
		end else if (cfg_valid && cfg_ready) begin
			tap_q <= tap_count;
		end
	end

	// history pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (accept && (cmd_t'(command) == CMD_CLEAR)) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (push) begin
			ptr_q  <= ptr_q + 1'b1;
			fill_q <= fill_next;
		end
	end

	// tap walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			m_q    <= TAPS_ONE;
			base_q <= '0;
		end else if (push) begin
			k_q    <= '0;
			m_q    <= m_next;
			base_q <= ptr_q;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
		end
	end

	afir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk     (clk),
		.wr_en   (accept && (cmd_t'(command) == CMD_WR_COEF)),
		.wr_addr (coeff_index),
		.wr_data (coeff_value),
		.rd_en   (issue),
		.rd_addr (k_q),
		.rd_data (coef_rd)
	);

	afir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (ptr_q),
		.wr_data (sample),
		.rd_en   (issue),
		.rd_addr (base_q - k_q),
		.rd_data (hist_rd)
	);

	// read and product stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && last_issue;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	// product register
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= $signed(coef_rd) * $signed(hist_rd);
		end
	end

	assign acc_sum = acc_q + {{(ACC_BITS - PROD_BITS){prod_s2[PROD_BITS-1]}}, prod_s2};

	// accumulator
	always_ff @(posedge clk) begin
		if (push) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((finish || (state_q == ST_HOLD)) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && out_free) begin
			out_q <= acc_sum;
		end else if ((state_q == ST_HOLD) && out_free) begin
			out_q <= acc_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = out_q;

	// checks on the sequencer and pipeline
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2))
		else $error("pipeline busy while idle");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= TAPS_FULL)
		else $error("fill count beyond store depth");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> ({1'b0, k_q} < m_q))
		else $error("tap walk past its end");

	a_push_walks: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (state_q == ST_ISSUE) && (k_q == '0))
		else $error("push did not start a walk");

	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !out_free) |=> (state_q == ST_HOLD) && out_valid_q)
		else $error("finished sum lost behind stalled output");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import afir_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int FULL_TAPS     = 32;
	localparam int LOAD_TAPS     = 48;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [TAP_BITS-1:0]           tap_count;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    command;
	logic [ADDR_BITS-1:0]          coeff_index;
	logic signed [SAMPLE_BITS-1:0] coeff_value;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [ACC_BITS-1:0]    filtered_sample;

	// filter model: coefficients, circular history, taps in use
	logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
	logic [ADDR_BITS-1:0]          hist_ptr;
	logic [TAP_BITS-1:0]           tap_reg;
	logic signed [ACC_BITS-1:0]    pending_sums [$];
	logic signed [ACC_BITS-1:0]    want_sum;

	int          failures  = 0;
	bit          send_calm = 1'b0;
	int unsigned hold_req  = 0;

	audio_convolution_fir u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.tap_count       (tap_count),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.coeff_index     (coeff_index),
		.coeff_value     (coeff_value),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.filtered_sample (filtered_sample)
	);

	always #6 clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// audio value with extremes mixed in
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SMP_MIN;
			1: return SMP_MAX;
			2: return '0;
			3: return '1;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// store the new sample and sum the newest taps against the coefficients
	function automatic logic signed [ACC_BITS-1:0] fir_sum(
			input logic signed [SAMPLE_BITS-1:0] smp);
		int unsigned taps;
		logic [ADDR_BITS-1:0] slot;
		logic signed [ACC_BITS-1:0] acc;
		if (tap_reg == '0)
			taps = 1;
		else if (tap_reg > TAPS_FULL)
			taps = MAX_TAPS;
		else
			taps = 32'(tap_reg);
		hist_mem[hist_ptr] = smp;
		acc = '0;
		for (int k = 0; k < taps; k++) begin
			slot = hist_ptr - ADDR_BITS'(k);
			acc = acc + hist_mem[slot] * coef_mem[k];
		end
		hist_ptr = hist_ptr + 1'b1;
		return acc;
	endfunction

	// apply one accepted item to the filter model
	function automatic void filter_accept(input cmd_t cmd, input logic [ADDR_BITS-1:0] idx,
			input logic signed [SAMPLE_BITS-1:0] coef, input logic signed [SAMPLE_BITS-1:0] smp);
		case (cmd)
			CMD_WR_COEF: coef_mem[idx] = coef;
			CMD_PUSH:    pending_sums.push_back(fir_sum(smp));
			CMD_CLEAR: begin
				foreach (hist_mem[i])
					hist_mem[i] = '0;
				hist_ptr = '0;
			end
			default: ;
		endcase
	endfunction

	// offer one item, hold it until taken; called and returns at a falling edge
	task automatic send_item(input cmd_t cmd, input logic [ADDR_BITS-1:0] idx,
			input logic signed [SAMPLE_BITS-1:0] coef, input logic signed [SAMPLE_BITS-1:0] smp);
		int unsigned gap;
		gap = send_calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command     <= cmd;
		coeff_index <= idx;
		coeff_value <= coef;
		sample      <= smp;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		filter_accept(cmd, idx, coef, smp);
		@(negedge clk);
	endtask

	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		send_item(CMD_PUSH, ADDR_BITS'($urandom), SAMPLE_BITS'($urandom), smp);
	endtask

	task automatic write_coef(input logic [ADDR_BITS-1:0] idx,
			input logic signed [SAMPLE_BITS-1:0] coef);
		send_item(CMD_WR_COEF, idx, coef, SAMPLE_BITS'($urandom));
	endtask

	task automatic clear_history();
		send_item(CMD_CLEAR, ADDR_BITS'($urandom), SAMPLE_BITS'($urandom),
			SAMPLE_BITS'($urandom));
	endtask

	task automatic send_unused();
		send_item(CMD_NONE, ADDR_BITS'($urandom), SAMPLE_BITS'($urandom),
			SAMPLE_BITS'($urandom));
	endtask

	// drain all sums, then let trailing writes and clears settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// tap count write, only while the block is idle
	task automatic set_taps(input logic [TAP_BITS-1:0] taps);
		tap_count <= taps;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tap_reg = taps;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_directed();
		// one tap from reset, sample and coefficient extremes
		write_coef('0, SMP_MIN);
		push_sample(SMP_MAX);
		push_sample(SMP_MIN);
		write_coef('0, SMP_MAX);
		push_sample(SMP_MIN);
		push_sample('0);
		push_sample(-16'sd1);
		send_item(CMD_NONE, '1, SMP_MIN, SMP_MAX);
		push_sample(16'sd1);
		// entries above index one stay unread while two taps are in use
		write_coef(ADDR_BITS'(1), SMP_MIN);
		write_coef('1, 16'sh5555);
		wait_idle();
		set_taps(TAP_BITS'(2));
		push_sample(16'sd100);
		push_sample(SMP_MAX);
		clear_history();
		push_sample(16'sd300);
		send_unused();
		push_sample(SMP_MIN);
		wait_idle();
		// zero taps behaves as one tap
		set_taps('0);
		push_sample(16'sd7);
		push_sample(SMP_MIN);
		wait_idle();
	endtask

	task automatic test_full_scale();
		// leading coefficients at the negative extreme
		for (int i = 0; i < FULL_TAPS; i++)
			write_coef(ADDR_BITS'(i), SMP_MIN);
		wait_idle();
		set_taps(TAP_BITS'(FULL_TAPS));
		clear_history();
		// history fills past the window, then the window of extremes
		for (int i = 0; i < FULL_TAPS + 4; i++)
			push_sample(SMP_MIN);
		push_sample(SMP_MAX);
		wait_idle();
	endtask

	task automatic test_load_coeffs();
		for (int i = LOAD_TAPS - 1; i >= 0; i--)
			write_coef(ADDR_BITS'(i), pick_sample());
		wait_idle();
	endtask

	task automatic test_backpressure();
		// long output hold while pushes keep coming
		set_taps(TAP_BITS'(3));
		send_calm = 1'b1;
		hold_req  = 300;
		repeat (40) push_sample(pick_sample());
		send_calm = 1'b0;
		wait_idle();
	endtask

	task automatic test_random();
		int unsigned roll;
		logic [TAP_BITS-1:0] taps;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: taps = '0;
				1: taps = TAP_BITS'(LOAD_TAPS);
				default: taps = TAP_BITS'($urandom_range(1, LOAD_TAPS));
			endcase
			set_taps(taps);
			send_calm = ($urandom_range(0, 3) == 0);
			repeat (50) begin
				roll = $urandom_range(0, 99);
				if (roll < 68)
					push_sample(pick_sample());
				else if (roll < 88)
					write_coef(ADDR_BITS'($urandom), pick_sample());
				else if (roll < 95)
					clear_history();
				else
					send_unused();
			end
			send_calm = 1'b0;
			wait_idle();
		end
	endtask

	// output stall: short bursts, calm stretches, and requested long holds
	initial begin
		int unsigned stall_left;
		int unsigned free_left;
		stall_left = 0;
		free_left  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				free_left  = 0;
				hold_req   = 0;
			end else if (stall_left == 0 && free_left == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					free_left = $urandom_range(30, 200);
				end else begin
					stall_left = pick_gap();
					free_left  = $urandom_range(1, 6);
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				free_left--;
			end
		end
	end

	// compare each taken result with the oldest predicted sum
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$error("filtered_sample: expected none, actual %0d", filtered_sample);
				failures++;
			end else begin
				want_sum = pending_sums.pop_front();
				if (filtered_sample !== want_sum) begin
					$error("filtered_sample: expected %0d, actual %0d", want_sum,
						filtered_sample);
					failures++;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		tap_count   = TAPS_ONE;
		in_valid    = 1'b0;
		command     = CMD_NONE;
		coeff_index = '0;
		coeff_value = '0;
		sample      = '0;
		foreach (hist_mem[i])
			hist_mem[i] = '0;
		hist_ptr = '0;
		tap_reg  = TAPS_ONE;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_full_scale();
		test_load_coeffs();
		test_backpressure();
		test_random();
		wait_idle();
		if (failures == 0)
			$display("audio_convolution_fir verification clean");
		else
			$display("audio_convolution_fir verification failed");
		$finish;
	end

	// run limit
	initial begin
		#(50_000_000);
		$display("audio_convolution_fir verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/afir_pkg.sv
hdl/afir_ram.sv
hdl/audio_convolution_fir.sv
test/tb_top.sv
